// ===== design/dgr_pkg.sv =====
package dgr_pkg;

    localparam int DEF_MAX_DETECTIONS = 16;
    localparam int DEF_MAX_KEEP       = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINK_DIST   = 3'd0,
        REG_NEW_RANGE   = 3'd1,
        REG_EXIST_RATIO = 3'd2,
        REG_NEW_RATIO   = 3'd3,
        REG_KEEP_COUNT  = 3'd4
    } cfg_reg_t;

    // reset values: 1.2 m link, 8 m range, 0.30 and 0.40 in Q0.8
    localparam logic [15:0] RST_LINK_DIST   = 16'd1200;
    localparam logic [15:0] RST_NEW_RANGE   = 16'd8000;
    localparam logic [7:0]  RST_EXIST_RATIO = 8'd77;
    localparam logic [7:0]  RST_NEW_RATIO   = 8'd102;
    localparam logic [2:0]  RST_KEEP_COUNT  = 3'd2;

    // frame entry: {z, y, x, center_x, confidence, area, id}
    localparam int ENTRY_W = 104;
    // previous-frame entry: {z, y, x, id}
    localparam int PRIOR_W = 56;

    typedef struct packed {
        logic [7:0]         id;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [15:0]        conf;
        logic [11:0]        cx;
    } keep_t;

    typedef struct packed {
        logic load_item;
        logic ev_init;
        logic cur_load;
        logic dsel_origin;
        logic prior_cmp;
        logic best_upd;
        logic dist0_cap;
        logic decide;
        logic finish;
        logic emit;
        logic emit_marker;
    } cmd_t;

    typedef struct packed {
        logic frame_empty;
        logic prior_empty;
        logic i_last;
        logic j_last;
        logic surv_none;
        logic out_free;
        logic emit_last;
    } sts_t;

endpackage

// ===== design/dgr_ram.sv =====
module dgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/dgr_ctrl.sv =====
module dgr_ctrl #(
    parameter int MAX_DETECTIONS = dgr_pkg::DEF_MAX_DETECTIONS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_last,
    output logic                              in_ready,
    input  dgr_pkg::sts_t                     sts,
    output dgr_pkg::cmd_t                     cmd,
    output logic [$clog2(MAX_DETECTIONS)-1:0] ev_idx,
    output logic [$clog2(MAX_DETECTIONS)-1:0] pr_idx
);

    localparam int IDX_W = $clog2(MAX_DETECTIONS);

    typedef enum logic [3:0] {
        S_IDLE, S_EV_INIT, S_F_RD, S_F_LAT, S_O_DIFF, S_O_SQ, S_O_SUM,
        S_P_RD, S_P_WAIT, S_P_SQ, S_P_SUM, S_DECIDE, S_FINISH, S_EMIT, S_MARK
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_last)
                    begin
                        state_reg <= S_EV_INIT;
                    end
                end
                S_EV_INIT:
                begin
                    i_reg     <= '0;
                    state_reg <= sts.frame_empty ? S_FINISH : S_F_RD;
                end
                S_F_RD:   state_reg <= S_F_LAT;
                S_F_LAT:  state_reg <= S_O_DIFF;
                S_O_DIFF: state_reg <= S_O_SQ;
                S_O_SQ:   state_reg <= S_O_SUM;
                S_O_SUM:
                begin
                    j_reg     <= '0;
                    state_reg <= sts.prior_empty ? S_DECIDE : S_P_RD;
                end
                S_P_RD:   state_reg <= S_P_WAIT;
                S_P_WAIT: state_reg <= S_P_SQ;
                S_P_SQ:   state_reg <= S_P_SUM;
                S_P_SUM:
                begin
                    if (sts.j_last)
                    begin
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        j_reg     <= j_reg + IDX_W'(1);
                        state_reg <= S_P_RD;
                    end
                end
                S_DECIDE:
                begin
                    if (sts.i_last)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= S_F_RD;
                    end
                end
                S_FINISH: state_reg <= sts.surv_none ? S_MARK : S_EMIT;
                S_EMIT:
                begin
                    if (sts.out_free && sts.emit_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_MARK:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign ev_idx   = i_reg;
    assign pr_idx   = j_reg;

    always_comb
    begin
        cmd             = '0;
        cmd.load_item   = (state_reg == S_IDLE) && in_valid;
        cmd.ev_init     = (state_reg == S_EV_INIT);
        cmd.cur_load    = (state_reg == S_F_LAT);
        cmd.dsel_origin = (state_reg == S_O_DIFF);
        cmd.dist0_cap   = (state_reg == S_O_SUM);
        cmd.prior_cmp   = (state_reg == S_P_WAIT);
        cmd.best_upd    = (state_reg == S_P_SUM);
        cmd.decide      = (state_reg == S_DECIDE);
        cmd.finish      = (state_reg == S_FINISH);
        cmd.emit        = (state_reg == S_EMIT) && sts.out_free;
        cmd.emit_marker = (state_reg == S_MARK) && sts.out_free;
    end

endmodule

// ===== design/dgr_datapath.sv =====
module dgr_datapath #(
    parameter int MAX_DETECTIONS = dgr_pkg::DEF_MAX_DETECTIONS,
    parameter int MAX_KEEP       = dgr_pkg::DEF_MAX_KEEP
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dgr_pkg::cmd_t                       cmd,
    output dgr_pkg::sts_t                       sts,
    input  logic [$clog2(MAX_DETECTIONS)-1:0]   ev_idx,
    input  logic [$clog2(MAX_DETECTIONS)-1:0]   pr_idx,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dgr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dgr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                present,
    input  logic [7:0]                          armor_id,
    input  logic signed [15:0]                  pos_x,
    input  logic signed [15:0]                  pos_y,
    input  logic signed [15:0]                  pos_z,
    input  logic [19:0]                         area,
    input  logic [15:0]                         confidence,
    input  logic [11:0]                         center_x,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                valid_res,
    output logic [7:0]                          kept_id,
    output logic signed [15:0]                  kept_x,
    output logic signed [15:0]                  kept_y,
    output logic signed [15:0]                  kept_z,
    output logic [15:0]                         kept_confidence,
    output logic [11:0]                         kept_center_x,
    output logic                                end_of_frame
);

    localparam int IDX_W  = $clog2(MAX_DETECTIONS);
    localparam int CNT_W  = $clog2(MAX_DETECTIONS + 1);
    localparam int KCNT_W = $clog2(MAX_KEEP + 1);

    // configuration registers
    logic [15:0] link_dist_reg;
    logic [15:0] new_range_reg;
    logic [7:0]  exist_ratio_reg;
    logic [7:0]  new_ratio_reg;
    logic [2:0]  keep_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_dist_reg   <= dgr_pkg::RST_LINK_DIST;
            new_range_reg   <= dgr_pkg::RST_NEW_RANGE;
            exist_ratio_reg <= dgr_pkg::RST_EXIST_RATIO;
            new_ratio_reg   <= dgr_pkg::RST_NEW_RATIO;
            keep_count_reg  <= dgr_pkg::RST_KEEP_COUNT;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dgr_pkg::REG_LINK_DIST:   link_dist_reg   <= cfg_data;
                dgr_pkg::REG_NEW_RANGE:   new_range_reg   <= cfg_data;
                dgr_pkg::REG_EXIST_RATIO: exist_ratio_reg <= cfg_data[7:0];
                dgr_pkg::REG_NEW_RATIO:   new_ratio_reg   <= cfg_data[7:0];
                dgr_pkg::REG_KEEP_COUNT:  keep_count_reg  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // fill counters, running largest area, bank select
    logic [CNT_W-1:0] frame_fill_reg;
    logic [CNT_W-1:0] prior_fill_reg;
    logic [CNT_W-1:0] nsurv_reg;
    logic [19:0]      largest_reg;
    logic             bank_reg;
    logic             frame_full;
    logic             store_item;

    assign frame_full = (frame_fill_reg == CNT_W'(MAX_DETECTIONS));
    assign store_item = cmd.load_item && present && !frame_full;

    // frame store
    logic [dgr_pkg::ENTRY_W-1:0] frame_rdata;

    dgr_ram #(
        .WIDTH (dgr_pkg::ENTRY_W),
        .DEPTH (MAX_DETECTIONS)
    ) u_frame_ram (
        .clk   (clk),
        .we    (store_item),
        .waddr (frame_fill_reg[IDX_W-1:0]),
        .wdata ({pos_z, pos_y, pos_x, center_x, confidence, area, armor_id}),
        .raddr (ev_idx),
        .rdata (frame_rdata)
    );

    // current detection under test
    dgr_pkg::keep_t    cur_reg;
    logic [19:0]       cur_area_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cur_load)
        begin
            cur_reg.id   <= frame_rdata[7:0];
            cur_area_reg <= frame_rdata[27:8];
            cur_reg.conf <= frame_rdata[43:28];
            cur_reg.cx   <= frame_rdata[55:44];
            cur_reg.x    <= frame_rdata[71:56];
            cur_reg.y    <= frame_rdata[87:72];
            cur_reg.z    <= frame_rdata[103:88];
        end
    end

    // previous-frame survivors, two banks: read one, refill the other
    logic                        prior_we;
    logic [dgr_pkg::PRIOR_W-1:0] prior_rdata;
    logic                        pass;

    assign prior_we = cmd.decide && pass;

    dgr_ram #(
        .WIDTH (dgr_pkg::PRIOR_W),
        .DEPTH (2 * MAX_DETECTIONS)
    ) u_prior_ram (
        .clk   (clk),
        .we    (prior_we),
        .waddr ({~bank_reg, nsurv_reg[IDX_W-1:0]}),
        .wdata ({cur_reg.z, cur_reg.y, cur_reg.x, cur_reg.id}),
        .raddr ({bank_reg, pr_idx}),
        .rdata (prior_rdata)
    );

    // squared distance pipeline: difference, squares, sum
    logic signed [15:0] ref_x, ref_y, ref_z;
    logic signed [16:0] dx_reg, dy_reg, dz_reg;
    logic signed [33:0] px, py, pz;
    logic [31:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [33:0]        dsum;
    logic [33:0]        best_reg;
    logic [33:0]        dist0_reg;
    logic               seen_reg;

    assign ref_x = cmd.dsel_origin ? 16'sd0 : prior_rdata[23:8];
    assign ref_y = cmd.dsel_origin ? 16'sd0 : prior_rdata[39:24];
    assign ref_z = cmd.dsel_origin ? 16'sd0 : prior_rdata[55:40];

    assign px   = dx_reg * dx_reg;
    assign py   = dy_reg * dy_reg;
    assign pz   = dz_reg * dz_reg;
    assign dsum = {2'b00, sqx_reg} + {2'b00, sqy_reg} + {2'b00, sqz_reg};

    always_ff @(posedge clk)
    begin
        dx_reg  <= {cur_reg.x[15], cur_reg.x} - {ref_x[15], ref_x};
        dy_reg  <= {cur_reg.y[15], cur_reg.y} - {ref_y[15], ref_y};
        dz_reg  <= {cur_reg.z[15], cur_reg.z} - {ref_z[15], ref_z};
        sqx_reg <= px[31:0];
        sqy_reg <= py[31:0];
        sqz_reg <= pz[31:0];
        if (cmd.cur_load)
        begin
            best_reg <= '1;
            seen_reg <= 1'b0;
        end
        else
        begin
            if (cmd.best_upd && (dsum < best_reg))
            begin
                best_reg <= dsum;
            end
            if (cmd.prior_cmp && (prior_rdata[7:0] == cur_reg.id))
            begin
                seen_reg <= 1'b1;
            end
        end
        if (cmd.dist0_cap)
        begin
            dist0_reg <= dsum;
        end
    end

    // thresholds, recomputed every cycle from stable registers
    logic [31:0] link2_reg;
    logic [31:0] range2_reg;
    logic [27:0] thr_e_reg;
    logic [27:0] thr_n_reg;
    logic [27:0] area256;

    always_ff @(posedge clk)
    begin
        link2_reg  <= link_dist_reg * link_dist_reg;
        range2_reg <= new_range_reg * new_range_reg;
        thr_e_reg  <= largest_reg * exist_ratio_reg;
        thr_n_reg  <= largest_reg * new_ratio_reg;
    end

    assign area256 = {cur_area_reg, 8'h00};

    always_comb
    begin
        pass = (prior_fill_reg == '0) || (best_reg <= {2'b00, link2_reg});
        if (seen_reg)
        begin
            pass = pass && (area256 >= thr_e_reg);
        end
        else
        begin
            pass = pass && (area256 >= thr_n_reg) && (dist0_reg <= {2'b00, range2_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_fill_reg <= '0;
            prior_fill_reg <= '0;
            nsurv_reg      <= '0;
            largest_reg    <= '0;
            bank_reg       <= 1'b0;
        end
        else
        begin
            if (store_item)
            begin
                frame_fill_reg <= frame_fill_reg + CNT_W'(1);
                if (area > largest_reg)
                begin
                    largest_reg <= area;
                end
            end
            if (cmd.ev_init)
            begin
                nsurv_reg <= '0;
            end
            if (prior_we)
            begin
                nsurv_reg <= nsurv_reg + CNT_W'(1);
            end
            if (cmd.finish)
            begin
                frame_fill_reg <= '0;
                largest_reg    <= '0;
                prior_fill_reg <= nsurv_reg;
                bank_reg       <= ~bank_reg;
            end
        end
    end

    // best survivors by confidence, earlier arrival wins a tie
    dgr_pkg::keep_t    top_q [MAX_KEEP];
    logic [KCNT_W-1:0] top_cnt_reg;
    logic [KCNT_W-1:0] ins_pos;

    always_comb
    begin
        ins_pos = '0;
        for (int k = 0; k < MAX_KEEP; k++)
        begin
            if ((KCNT_W'(k) < top_cnt_reg) && (top_q[k].conf >= cur_reg.conf))
            begin
                ins_pos = ins_pos + KCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prior_we && (ins_pos < KCNT_W'(MAX_KEEP)))
        begin
            for (int k = MAX_KEEP - 1; k >= 1; k--)
            begin
                if (KCNT_W'(k) > ins_pos)
                begin
                    top_q[k] <= top_q[k-1];
                end
            end
            for (int k = 0; k < MAX_KEEP; k++)
            begin
                if (KCNT_W'(k) == ins_pos)
                begin
                    top_q[k] <= cur_reg;
                end
            end
        end
    end

    // emit in rising image x among the first nkeep ranked entries
    logic [KCNT_W-1:0]   limit;
    logic [KCNT_W-1:0]   nkeep;
    logic [KCNT_W-1:0]   emit_cnt_reg;
    logic [MAX_KEEP-1:0] emitted_reg;
    logic [MAX_KEEP-1:0] pick_oh;
    dgr_pkg::keep_t      pick_ent;
    logic [11:0]         pick_cx;
    logic                pick_found;

    always_comb
    begin
        if (keep_count_reg == 3'd0)
        begin
            limit = KCNT_W'(1);
        end
        else if (int'(keep_count_reg) > MAX_KEEP)
        begin
            limit = KCNT_W'(MAX_KEEP);
        end
        else
        begin
            limit = KCNT_W'(keep_count_reg);
        end
        nkeep = (top_cnt_reg < limit) ? top_cnt_reg : limit;
    end

    always_comb
    begin
        pick_oh    = '0;
        pick_ent   = top_q[0];
        pick_cx    = '0;
        pick_found = 1'b0;
        for (int k = 0; k < MAX_KEEP; k++)
        begin
            if ((KCNT_W'(k) < nkeep) && !emitted_reg[k]
                && (!pick_found || (top_q[k].cx < pick_cx)))
            begin
                pick_found = 1'b1;
                pick_cx    = top_q[k].cx;
                pick_ent   = top_q[k];
                pick_oh    = '0;
                pick_oh[k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_cnt_reg  <= '0;
            emit_cnt_reg <= '0;
            emitted_reg  <= '0;
        end
        else
        begin
            if (cmd.ev_init)
            begin
                top_cnt_reg  <= '0;
                emit_cnt_reg <= '0;
                emitted_reg  <= '0;
            end
            else
            begin
                if (prior_we && (top_cnt_reg < KCNT_W'(MAX_KEEP)))
                begin
                    top_cnt_reg <= top_cnt_reg + KCNT_W'(1);
                end
                if (cmd.emit)
                begin
                    emit_cnt_reg <= emit_cnt_reg + KCNT_W'(1);
                    emitted_reg  <= emitted_reg | pick_oh;
                end
            end
        end
    end

    // output register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit || cmd.emit_marker)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            valid_res       <= 1'b1;
            kept_id         <= pick_ent.id;
            kept_x          <= pick_ent.x;
            kept_y          <= pick_ent.y;
            kept_z          <= pick_ent.z;
            kept_confidence <= pick_ent.conf;
            kept_center_x   <= pick_ent.cx;
            end_of_frame    <= sts.emit_last;
        end
        else if (cmd.emit_marker)
        begin
            valid_res       <= 1'b0;
            kept_id         <= '0;
            kept_x          <= '0;
            kept_y          <= '0;
            kept_z          <= '0;
            kept_confidence <= '0;
            kept_center_x   <= '0;
            end_of_frame    <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

    assign sts.frame_empty = (frame_fill_reg == '0);
    assign sts.prior_empty = (prior_fill_reg == '0);
    assign sts.i_last      = ((CNT_W'(ev_idx) + CNT_W'(1)) == frame_fill_reg);
    assign sts.j_last      = ((CNT_W'(pr_idx) + CNT_W'(1)) == prior_fill_reg);
    assign sts.surv_none   = (nsurv_reg == '0);
    assign sts.out_free    = !out_valid_reg || out_ready;
    assign sts.emit_last   = ((emit_cnt_reg + KCNT_W'(1)) == nkeep);

    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_cnt_reg <= KCNT_W'(MAX_KEEP))
        else $error("ranking list overfilled");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_fill_reg <= CNT_W'(MAX_DETECTIONS))
        else $error("frame store overfilled");

    a_finish_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (frame_fill_reg == '0) && (largest_reg == '0))
        else $error("frame state not cleared after evaluation");

    a_emit_pick: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> $onehot(pick_oh))
        else $error("emit without a remaining candidate");

endmodule

// ===== design/detection_gate_and_rank.sv =====
// Detection gate and rank.
// Input channel (in_valid/in_ready): one transaction per detection of a frame,
// last marks the final one. present 0 carries no detection. Items beyond the
// frame store depth are dropped. Non-final items are taken one per cycle.
// After the final item the frame is evaluated: one shared squared-distance
// unit walks every pair of the N stored detections and the P survivors of
// the previous frame. Then 1 to MAX_KEEP results leave in rising image x, one
// per cycle while the receiver is ready, end_of_frame on the last; a frame
// without survivors yields a single marker with valid_res 0. No new input
// transaction is taken until the last result of the frame is loaded into the
// output register.
// Output channel (out_valid/out_ready): a stalled receiver holds the result
// register and the block waits for it.
// Config channel (cfg_valid/cfg_ready): always ready, write only while idle.
// Reset clears the fill counts, the previous-frame survivor set and the
// configuration to its defaults.
module detection_gate_and_rank #(
    parameter int MAX_DETECTIONS = dgr_pkg::DEF_MAX_DETECTIONS,
    parameter int MAX_KEEP       = dgr_pkg::DEF_MAX_KEEP
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dgr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dgr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           present,
    input  logic [7:0]                     armor_id,
    input  logic signed [15:0]             pos_x,
    input  logic signed [15:0]             pos_y,
    input  logic signed [15:0]             pos_z,
    input  logic [19:0]                    area,
    input  logic [15:0]                    confidence,
    input  logic [11:0]                    center_x,
    input  logic                           last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           valid_res,
    output logic [7:0]                     kept_id,
    output logic signed [15:0]             kept_x,
    output logic signed [15:0]             kept_y,
    output logic signed [15:0]             kept_z,
    output logic [15:0]                    kept_confidence,
    output logic [11:0]                    kept_center_x,
    output logic                           end_of_frame
);

    localparam int IDX_W = $clog2(MAX_DETECTIONS);

    dgr_pkg::cmd_t    cmd;
    dgr_pkg::sts_t    sts;
    logic [IDX_W-1:0] ev_idx;
    logic [IDX_W-1:0] pr_idx;

    dgr_ctrl #(
        .MAX_DETECTIONS (MAX_DETECTIONS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (last),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd),
        .ev_idx   (ev_idx),
        .pr_idx   (pr_idx)
    );

    dgr_datapath #(
        .MAX_DETECTIONS (MAX_DETECTIONS),
        .MAX_KEEP       (MAX_KEEP)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .ev_idx          (ev_idx),
        .pr_idx          (pr_idx),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .present         (present),
        .armor_id        (armor_id),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .area            (area),
        .confidence      (confidence),
        .center_x        (center_x),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .valid_res       (valid_res),
        .kept_id         (kept_id),
        .kept_x          (kept_x),
        .kept_y          (kept_y),
        .kept_z          (kept_z),
        .kept_confidence (kept_confidence),
        .kept_center_x   (kept_center_x),
        .end_of_frame    (end_of_frame)
    );

endmodule

// ===== verif/dgr_checker.sv =====
module dgr_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               present,
    input  logic [7:0]         armor_id,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    input  logic [19:0]        area,
    input  logic [15:0]        confidence,
    input  logic [11:0]        center_x,
    input  logic               last,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               valid_res,
    input  logic [7:0]         kept_id,
    input  logic signed [15:0] kept_x,
    input  logic signed [15:0] kept_y,
    input  logic signed [15:0] kept_z,
    input  logic [15:0]        kept_confidence,
    input  logic [11:0]        kept_center_x,
    input  logic               end_of_frame,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = dgr_pkg::DEF_MAX_DETECTIONS;

    typedef struct packed {
        logic               vld;
        logic [7:0]         id;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [15:0]        conf;
        logic [11:0]        cx;
        logic               eof;
    } kept_result_t;

    typedef struct {
        logic [7:0]         id;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [19:0]        ar;
        logic [15:0]        conf;
        logic [11:0]        cx;
    } detection_t;

    logic [15:0] link_mm, range_mm;
    logic [7:0]  exist_ratio, new_ratio;
    logic [2:0]  keep_cnt;
    detection_t  frame_buf[DEPTH];
    int          frame_cnt;
    detection_t  prior_buf[DEPTH];
    int          prior_cnt;
    kept_result_t kept_q[$];

    assign pending = kept_q.size();

    function automatic longint sq_dist(detection_t a, detection_t b);
        longint dx, dy, dz;
        dx = longint'(a.x) - longint'(b.x);
        dy = longint'(a.y) - longint'(b.y);
        dz = longint'(a.z) - longint'(b.z);
        return dx * dx + dy * dy + dz * dz;
    endfunction

    task automatic gate_and_rank_frame();
        int         surv[$];
        int         pick[$];
        bit         taken[DEPTH];
        longint     largest, best, link2, range2, area256;
        bit         seen;
        int         limit, nkeep, bi, v, j;
        detection_t org;
        kept_result_t r;
        largest = 0;
        org = '{default: '0};
        for (int i = 0; i < frame_cnt; i++)
            if (frame_buf[i].ar > largest) largest = frame_buf[i].ar;
        link2 = longint'(link_mm) * link_mm;
        range2 = longint'(range_mm) * range_mm;
        for (int i = 0; i < frame_cnt; i++)
        begin
            seen = 0;
            area256 = longint'(frame_buf[i].ar) << 8;
            if (prior_cnt > 0)
            begin
                best = 64'h7fff_ffff_ffff_ffff;
                for (int k = 0; k < prior_cnt; k++)
                begin
                    if (sq_dist(prior_buf[k], frame_buf[i]) < best)
                        best = sq_dist(prior_buf[k], frame_buf[i]);
                    if (prior_buf[k].id == frame_buf[i].id) seen = 1;
                end
                if (best > link2) continue;
            end
            if (seen)
            begin
                if (area256 < largest * exist_ratio) continue;
            end
            else
            begin
                if (area256 < largest * new_ratio) continue;
                if (sq_dist(frame_buf[i], org) > range2) continue;
            end
            surv.push_back(i);
        end
        foreach (surv[k]) prior_buf[k] = frame_buf[surv[k]];
        prior_cnt = surv.size();
        if (surv.size() == 0)
        begin
            r = '0;
            r.eof = 1;
            kept_q.push_back(r);
        end
        else
        begin
            limit = (keep_cnt < 1) ? 1 :
                    (keep_cnt > dgr_pkg::DEF_MAX_KEEP) ? dgr_pkg::DEF_MAX_KEEP : keep_cnt;
            nkeep = (surv.size() < limit) ? surv.size() : limit;
            foreach (taken[k]) taken[k] = 0;
            for (int i = 0; i < nkeep; i++)
            begin
                bi = -1;
                for (int k = 0; k < surv.size(); k++)
                    if (!taken[k] && (bi < 0 ||
                        frame_buf[surv[k]].conf > frame_buf[surv[bi]].conf)) bi = k;
                taken[bi] = 1;
                pick.push_back(surv[bi]);
            end
            // stable order by image x
            for (int i = 1; i < nkeep; i++)
            begin
                v = pick[i];
                j = i;
                while (j > 0 && frame_buf[pick[j-1]].cx > frame_buf[v].cx)
                begin
                    pick[j] = pick[j-1];
                    j--;
                end
                pick[j] = v;
            end
            for (int i = 0; i < nkeep; i++)
            begin
                r.vld = 1;
                r.id = frame_buf[pick[i]].id;
                r.x = frame_buf[pick[i]].x;
                r.y = frame_buf[pick[i]].y;
                r.z = frame_buf[pick[i]].z;
                r.conf = frame_buf[pick[i]].conf;
                r.cx = frame_buf[pick[i]].cx;
                r.eof = (i == nkeep - 1);
                kept_q.push_back(r);
            end
        end
        frame_cnt = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        kept_result_t got, exp_r;
        if (!rst_n)
        begin
            link_mm = dgr_pkg::RST_LINK_DIST;
            range_mm = dgr_pkg::RST_NEW_RANGE;
            exist_ratio = dgr_pkg::RST_EXIST_RATIO;
            new_ratio = dgr_pkg::RST_NEW_RATIO;
            keep_cnt = dgr_pkg::RST_KEEP_COUNT;
            frame_cnt = 0;
            prior_cnt = 0;
            fail_count = 0;
            kept_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (dgr_pkg::cfg_reg_t'(cfg_index))
                    dgr_pkg::REG_LINK_DIST:   link_mm = cfg_data;
                    dgr_pkg::REG_NEW_RANGE:   range_mm = cfg_data;
                    dgr_pkg::REG_EXIST_RATIO: exist_ratio = cfg_data[7:0];
                    dgr_pkg::REG_NEW_RATIO:   new_ratio = cfg_data[7:0];
                    dgr_pkg::REG_KEEP_COUNT:  keep_cnt = cfg_data[2:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got = '{valid_res, kept_id, kept_x, kept_y, kept_z, kept_confidence,
                        kept_center_x, end_of_frame};
                if (kept_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    exp_r = kept_q.pop_front();
                    if (got !== exp_r)
                    begin
                        $display("%0t: result mismatch, expected %h, actual %h",
                                 $time, exp_r, got);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (present && frame_cnt < DEPTH)
                begin
                    frame_buf[frame_cnt] = '{armor_id, pos_x, pos_y, pos_z, area,
                                             confidence, center_x};
                    frame_cnt++;
                end
                if (last) gate_and_rank_frame();
            end
        end
    end
endmodule

// ===== verif/tb_detection_gate_and_rank.sv =====
module tb_detection_gate_and_rank;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic               clk, rst_n;
    logic               cfg_valid, cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid, in_ready;
    logic               present, last;
    logic [7:0]         armor_id;
    logic signed [15:0] pos_x, pos_y, pos_z;
    logic [19:0]        area;
    logic [15:0]        confidence;
    logic [11:0]        center_x;
    logic               out_valid, out_ready;
    logic               valid_res, end_of_frame;
    logic [7:0]         kept_id;
    logic signed [15:0] kept_x, kept_y, kept_z;
    logic [15:0]        kept_confidence;
    logic [11:0]        kept_center_x;
    int                 fail_count, pending;
    int                 send_idle_pct, recv_stall_pct;
    int                 quiet_cycles;
    int                 item_total;

    detection_gate_and_rank u_top (.*);
    dgr_checker u_chk (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // receiver stalls
    always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog on lack of progress
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(dgr_pkg::cfg_reg_t idx, logic [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 0;
        @(negedge clk);
    endtask

    // valid stays up after the transaction so the next one can follow directly
    task automatic send_detection(logic p, logic [7:0] id, logic [15:0] x, logic [15:0] y,
                                  logic [15:0] z, logic [19:0] ar, logic [15:0] cf,
                                  logic [11:0] cx, logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        present <= p;
        armor_id <= id;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        area <= ar;
        confidence <= cf;
        center_x <= cx;
        last <= lst;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        item_total++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pending > 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    // mostly near targets that pass the gates, sometimes anything
    task automatic random_frame(int n, int wild_pct);
        logic [15:0] bx, by, bz;
        logic [19:0] ar;
        bit          wild;
        bx = 16'($urandom_range(4000) - 2000);
        by = 16'($urandom_range(4000) - 2000);
        bz = 16'($urandom_range(4000) + 500);
        for (int i = 0; i < n; i++)
        begin
            wild = ($urandom_range(99) < wild_pct);
            ar = wild ? 20'($urandom) : 20'($urandom_range(4000, 1000));
            send_detection($urandom_range(9) != 0, wild ? 8'($urandom) : 8'($urandom_range(5)),
                           wild ? 16'($urandom) : 16'(bx + $urandom_range(600) - 300),
                           wild ? 16'($urandom) : 16'(by + $urandom_range(600) - 300),
                           wild ? 16'($urandom) : 16'(bz + $urandom_range(600) - 300),
                           ar, 16'($urandom), 12'($urandom), i == n - 1);
        end
    endtask

    initial
    begin
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 0;
        present = 0;
        armor_id = 0;
        pos_x = 0;
        pos_y = 0;
        pos_z = 0;
        area = 0;
        confidence = 0;
        center_x = 0;
        last = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        item_total = 0;
        rst_n = 0;
        repeat (9) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: empty frame, extremes, ties, keep_count extremes
        send_detection(0, 0, 0, 0, 0, 0, 0, 0, 1);
        send_detection(1, 8'hff, 16'h7fff, 16'h8000, 16'h7fff, 20'hfffff, 16'hffff,
                       12'hfff, 1);
        send_detection(1, 1, 100, 100, 1000, 5000, 500, 300, 0);
        send_detection(1, 2, 120, 90, 1000, 5000, 500, 300, 0);
        send_detection(1, 3, 80, 110, 1010, 4000, 900, 10, 0);
        send_detection(0, 9, 0, 0, 0, 0, 0, 0, 1);
        send_detection(1, 1, 110, 100, 1000, 100, 700, 50, 0);
        send_detection(1, 7, -16'sd50, 150, 990, 3000, 700, 50, 1);
        drain();
        write_reg(dgr_pkg::REG_KEEP_COUNT, 16'd0);
        write_reg(dgr_pkg::REG_LINK_DIST, 16'hffff);
        write_reg(dgr_pkg::REG_NEW_RANGE, 16'hffff);
        write_reg(dgr_pkg::REG_EXIST_RATIO, 16'd0);
        write_reg(dgr_pkg::REG_NEW_RATIO, 16'd0);
        // overfill the frame store
        for (int i = 0; i < 18; i++)
            send_detection(1, 8'(i), 16'(-i * 10), 16'(i), 16'h8000, 20'(i), 16'($urandom),
                           12'($urandom), i == 17);
        drain();
        write_reg(dgr_pkg::REG_KEEP_COUNT, 16'd7);
        write_reg(dgr_pkg::REG_EXIST_RATIO, 16'd255);
        write_reg(dgr_pkg::REG_NEW_RATIO, 16'd255);
        random_frame(5, 10);
        drain();
        write_reg(dgr_pkg::REG_KEEP_COUNT, 16'd4);
        write_reg(dgr_pkg::REG_LINK_DIST, 16'd0);
        write_reg(dgr_pkg::REG_NEW_RANGE, 16'd0);
        random_frame(3, 10);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 24 : 59) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 24 : 59) : 0;
            write_reg(dgr_pkg::REG_LINK_DIST, (ph == 3) ? 16'd300 : 16'(1200 + ph * 400));
            write_reg(dgr_pkg::REG_NEW_RANGE, (ph == 2) ? 16'hffff : 16'd8000);
            write_reg(dgr_pkg::REG_EXIST_RATIO, 16'($urandom_range(120)));
            write_reg(dgr_pkg::REG_NEW_RATIO, 16'($urandom_range(160)));
            write_reg(dgr_pkg::REG_KEEP_COUNT, 16'($urandom_range(5, 1)));
            for (int f = 0; f < 9; f++) random_frame($urandom_range(6, 1), 15);
            drain();
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
